/* rtl/bounded_sequence_store_core_macros.svh */
// assertion helpers used by bss_dpath
`ifndef BOUNDED_SEQUENCE_STORE_CORE_MACROS_SVH
`define BOUNDED_SEQUENCE_STORE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BSS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bss_pkg.sv */
`timescale 1ns / 1ps

package bss_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int MODE_W = 4;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_INS_FRONT  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_INS_BACK   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_INS_SECOND = 4'd2;
  localparam logic [MODE_W-1:0] MODE_INS_NTL    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_FIRST  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_DEL_SECOND = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DEL_LAST   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DEL_MAX    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_READ       = 4'd8;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_FEW   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS,
    OP_DEL,
    OP_MAX,
    OP_READ
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_MOVE,
    S_INS_DRAIN,
    S_INS_WRITE,
    S_DEL_MOVE,
    S_SCAN,
    S_SCAN_END,
    S_READ_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load_item;
    logic decide;
    logic ins_move;
    logic ins_write;
    logic del_move;
    logic scan;
    logic scan_end;
    logic read_capture;
    logic resp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ins_move_needed;
    logic ins_last;
    logic del_more;
    logic scan_more;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/bss_if.sv */
`timescale 1ns / 1ps

interface bss_in_if;
  logic                              valid;
  logic                              ready;
  logic        [bss_pkg::MODE_W-1:0] mode;
  logic signed [bss_pkg::DATA_W-1:0] value;
  logic        [bss_pkg::POS_W-1:0]  position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink (input valid, input mode, input value, input position, output ready);
endinterface

interface bss_out_if;
  logic                              valid;
  logic                              ready;
  logic        [bss_pkg::CNT_W-1:0]  entry_count;
  logic                              is_empty;
  logic signed [bss_pkg::DATA_W-1:0] read_value;
  logic        [bss_pkg::STAT_W-1:0] status;

  modport source (output valid, output entry_count, output is_empty, output read_value,
                  output status, input ready);
  modport sink (input valid, input entry_count, input is_empty, input read_value,
                input status, output ready);
endinterface

/* rtl/bounded_sequence_store_core.sv */
`timescale 1ns / 1ps
// bounded sequence store: ordered list of up to 16 signed 32-bit entries
// req channel (valid/ready): mode, value, position; one transaction per item
// rsp channel (valid/ready): entry_count, is_empty, read_value, status
// every request yields exactly one response, in order
// one item is worked at a time; req.ready is high only while the controller idles
// a rejected request, no-op or unused mode goes straight to the response; an insert
// at the back writes at once, elsewhere it first moves the entries from the target
// index on one place back, one entry moved per cycle; a delete moves the entries
// after its target one place forward; delete largest first scans for the largest
// entry; the slowest request deletes the largest entry at the front of a full store
// a new request is taken in the cycle after the previous response is registered
// the response sits in an output register; while rsp.ready is low it holds, the
// next request is still accepted and worked, and then waits for the register to free
// reset (rst, synchronous) empties the store and drops any pending response

module bounded_sequence_store_core (
  input logic      clk,
  input logic      rst,
  bss_in_if.sink   req,
  bss_out_if.source rsp
);

  bss_pkg::ctrl_cmd_t  cmd;
  bss_pkg::dp_status_t stat;

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bss_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (req.mode),
    .value       (req.value),
    .position    (req.position),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .entry_count (rsp.entry_count),
    .is_empty    (rsp.is_empty),
    .read_value  (rsp.read_value),
    .status      (rsp.status)
  );

endmodule

/* rtl/bss_ctrl.sv */
`timescale 1ns / 1ps

module bss_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bss_pkg::dp_status_t    stat,
  output bss_pkg::ctrl_cmd_t     cmd
);

  bss_pkg::state_t state;
  bss_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bss_pkg::S_IDLE: begin
        if (in_valid) state_next = bss_pkg::S_DECIDE;
      end
      bss_pkg::S_DECIDE: begin
        unique case (stat.op)
          bss_pkg::OP_INS: begin
            state_next = stat.ins_move_needed ? bss_pkg::S_INS_MOVE : bss_pkg::S_INS_WRITE;
          end
          bss_pkg::OP_DEL:  state_next = bss_pkg::S_DEL_MOVE;
          bss_pkg::OP_MAX:  state_next = bss_pkg::S_SCAN;
          bss_pkg::OP_READ: state_next = bss_pkg::S_READ_WAIT;
          default:          state_next = bss_pkg::S_RESP;
        endcase
      end
      bss_pkg::S_INS_MOVE: begin
        if (stat.ins_last) state_next = bss_pkg::S_INS_DRAIN;
      end
      bss_pkg::S_INS_DRAIN: state_next = bss_pkg::S_INS_WRITE;
      bss_pkg::S_INS_WRITE: state_next = bss_pkg::S_RESP;
      bss_pkg::S_DEL_MOVE: begin
        if (!stat.del_more) state_next = bss_pkg::S_RESP;
      end
      bss_pkg::S_SCAN: begin
        if (!stat.scan_more) state_next = bss_pkg::S_SCAN_END;
      end
      bss_pkg::S_SCAN_END:  state_next = bss_pkg::S_DEL_MOVE;
      bss_pkg::S_READ_WAIT: state_next = bss_pkg::S_RESP;
      bss_pkg::S_RESP: begin
        if (stat.out_free) state_next = bss_pkg::S_IDLE;
      end
      default: state_next = bss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      bss_pkg::S_IDLE: begin
        // no transaction is taken while reset is held
        in_ready      = !rst;
        cmd.load_item = in_valid && !rst;
      end
      bss_pkg::S_DECIDE:    cmd.decide       = 1'b1;
      bss_pkg::S_INS_MOVE:  cmd.ins_move     = 1'b1;
      bss_pkg::S_INS_DRAIN: cmd              = '0;
      bss_pkg::S_INS_WRITE: cmd.ins_write    = 1'b1;
      bss_pkg::S_DEL_MOVE:  cmd.del_move     = 1'b1;
      bss_pkg::S_SCAN:      cmd.scan         = 1'b1;
      bss_pkg::S_SCAN_END:  cmd.scan_end     = 1'b1;
      bss_pkg::S_READ_WAIT: cmd.read_capture = 1'b1;
      bss_pkg::S_RESP:      cmd.resp_load    = stat.out_free;
      default:              cmd              = '0;
    endcase
  end

endmodule

/* rtl/bss_dpath.sv */
`timescale 1ns / 1ps
`include "bounded_sequence_store_core_macros.svh"

module bss_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  bss_pkg::ctrl_cmd_t                cmd,
  output bss_pkg::dp_status_t               stat,
  input  logic        [bss_pkg::MODE_W-1:0] mode,
  input  logic signed [bss_pkg::DATA_W-1:0] value,
  input  logic        [bss_pkg::POS_W-1:0]  position,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic        [bss_pkg::CNT_W-1:0]  entry_count,
  output logic                              is_empty,
  output logic signed [bss_pkg::DATA_W-1:0] read_value,
  output logic        [bss_pkg::STAT_W-1:0] status
);

  localparam int CNT_W = bss_pkg::CNT_W;
  localparam int IDX_W = bss_pkg::IDX_W;

  // sequence storage, entry 0 is the front
  logic signed [bss_pkg::DATA_W-1:0] mem [bss_pkg::DEPTH];
  logic signed [bss_pkg::DATA_W-1:0] rdata;

  logic        [bss_pkg::MODE_W-1:0] mode_q;
  logic signed [bss_pkg::DATA_W-1:0] value_q;
  logic        [bss_pkg::POS_W-1:0]  pos_q;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] tgt;
  logic [CNT_W-1:0] ptr_inc;
  logic [CNT_W-1:0] ptr_dec;
  logic [IDX_W-1:0] wdst;
  logic             wpend;

  logic signed [bss_pkg::DATA_W-1:0] best_val;
  logic        [IDX_W-1:0]           best_idx;

  bss_pkg::status_t                  status_q;
  logic signed [bss_pkg::DATA_W-1:0] rd_q;

  bss_pkg::op_t     op_c;
  bss_pkg::status_t stat_c;
  logic [CNT_W-1:0] tgt_c;
  logic [CNT_W-1:0] raddr_c;
  logic             pos_ok;

  assign ptr_inc = ptr + CNT_W'(1);
  assign ptr_dec = ptr - CNT_W'(1);
  assign pos_ok  = (32'(pos_q) < 32'(count)) && (32'(pos_q) < 32'(bss_pkg::DEPTH));

  always_comb begin
    op_c   = bss_pkg::OP_NONE;
    stat_c = bss_pkg::ST_DONE;
    tgt_c  = '0;
    unique case (mode_q) inside
      bss_pkg::MODE_INS_FRONT, bss_pkg::MODE_INS_BACK,
      bss_pkg::MODE_INS_SECOND, bss_pkg::MODE_INS_NTL: begin
        if (count >= CNT_W'(bss_pkg::DEPTH)) begin
          stat_c = bss_pkg::ST_FULL;
        end else if (count == '0 && (mode_q == bss_pkg::MODE_INS_SECOND ||
                                      mode_q == bss_pkg::MODE_INS_NTL)) begin
          stat_c = bss_pkg::ST_FEW;
        end else begin
          op_c = bss_pkg::OP_INS;
          if (mode_q == bss_pkg::MODE_INS_FRONT) begin
            tgt_c = '0;
          end else if (mode_q == bss_pkg::MODE_INS_BACK) begin
            tgt_c = count;
          end else if (mode_q == bss_pkg::MODE_INS_SECOND) begin
            tgt_c = CNT_W'(1);
          end else begin
            // single entry: new value lands at the front
            tgt_c = (count == CNT_W'(1)) ? '0 : count - CNT_W'(1);
          end
        end
      end
      bss_pkg::MODE_DEL_FIRST, bss_pkg::MODE_DEL_LAST, bss_pkg::MODE_DEL_MAX: begin
        if (count == '0) begin
          stat_c = bss_pkg::ST_FEW;
        end else if (mode_q == bss_pkg::MODE_DEL_MAX) begin
          op_c = bss_pkg::OP_MAX;
        end else begin
          op_c  = bss_pkg::OP_DEL;
          tgt_c = (mode_q == bss_pkg::MODE_DEL_FIRST) ? '0 : count - CNT_W'(1);
        end
      end
      bss_pkg::MODE_DEL_SECOND: begin
        if (count < CNT_W'(2)) begin
          stat_c = bss_pkg::ST_FEW;
        end else begin
          op_c  = bss_pkg::OP_DEL;
          tgt_c = CNT_W'(1);
        end
      end
      bss_pkg::MODE_READ: begin
        if (pos_ok) begin
          op_c  = bss_pkg::OP_READ;
          tgt_c = CNT_W'(pos_q);
        end else begin
          stat_c = bss_pkg::ST_RANGE;
        end
      end
      default: begin
        op_c = bss_pkg::OP_NONE;
      end
    endcase
  end

  always_comb begin
    stat.op              = op_c;
    stat.ins_move_needed = count > tgt_c;
    stat.ins_last        = ptr_dec == tgt;
    stat.del_more        = ptr_inc < count;
    stat.scan_more       = ptr < count;
    stat.out_free        = !out_valid || out_ready;
  end

  always_comb begin
    raddr_c = ptr;
    if (cmd.decide) begin
      raddr_c = (op_c == bss_pkg::OP_READ) ? tgt_c : '0;
    end else if (cmd.ins_move) begin
      raddr_c = ptr_dec;
    end else if (cmd.del_move) begin
      raddr_c = ptr_inc;
    end
  end

  // one move per cycle: read the source now, write it to wdst next cycle
  always_ff @(posedge clk) begin
    if (wpend) begin
      mem[wdst] <= rdata;
    end else if (cmd.ins_write) begin
      mem[tgt[IDX_W-1:0]] <= value_q;
    end
    rdata <= mem[raddr_c[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_q  <= mode;
      value_q <= value;
      pos_q   <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wpend <= 1'b0;
    end else begin
      wpend <= cmd.ins_move || (cmd.del_move && stat.del_more);
      if (cmd.ins_write) begin
        count <= count + CNT_W'(1);
      end else if (cmd.del_move && !stat.del_more) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      tgt      <= tgt_c;
      status_q <= stat_c;
      rd_q     <= '0;
      unique case (op_c)
        bss_pkg::OP_INS: ptr <= count;
        bss_pkg::OP_DEL: ptr <= tgt_c;
        bss_pkg::OP_MAX: ptr <= CNT_W'(1);
        default:         ptr <= ptr;
      endcase
    end else if (cmd.ins_move) begin
      ptr  <= ptr_dec;
      wdst <= ptr[IDX_W-1:0];
    end else if (cmd.del_move && stat.del_more) begin
      ptr  <= ptr_inc;
      wdst <= ptr[IDX_W-1:0];
    end else if (cmd.scan && stat.scan_more) begin
      ptr <= ptr_inc;
    end else if (cmd.scan_end) begin
      ptr <= CNT_W'(best_idx);
    end
    // rdata holds entry ptr-1 during the scan; strict compare keeps the frontmost tie
    if (cmd.scan && (ptr == CNT_W'(1) || rdata > best_val)) begin
      best_val <= rdata;
      best_idx <= ptr_dec[IDX_W-1:0];
    end
    if (cmd.read_capture) begin
      rd_q <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      entry_count <= count;
      is_empty    <= (count == '0);
      read_value  <= rd_q;
      status      <= status_q;
    end
  end

  `BSS_ASSERT_IMP(a_no_write_clash, clk, rst, cmd.ins_write, !wpend, "insert write collides with move")
  `BSS_ASSERT_NXT(a_ins_count, clk, rst, cmd.ins_write, count == $past(count) + CNT_W'(1), "count not bumped on insert")
  `BSS_ASSERT_IMP(a_resp_slot, clk, rst, cmd.resp_load, !out_valid || out_ready, "result overwrites pending transaction")
  `BSS_ASSERT_IMP(a_max_nonempty, clk, rst, cmd.decide && op_c == bss_pkg::OP_MAX, count != '0, "largest-value delete on empty store")

endmodule
